// File: hdl/gti_pkg.sv
package gti_pkg;

  // Field widths
  localparam int X_W      = 16;
  localparam int STEP_W   = 16;
  localparam int RES_W    = 19;
  localparam int USED_W   = 4;

  // Integrator limits and fixed-point format
  localparam int MAX_POINTS = 9;
  localparam int FRAC_BITS  = 16;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Exponent datapath widths
  localparam int MAG_W  = X_W;
  localparam int SQ_W   = 2 * MAG_W - 1;
  localparam int LOG_W  = 17;
  localparam int T_W    = SQ_W + LOG_W;
  localparam int K_W    = T_W - 32;
  localparam int V_W    = 17;
  localparam int F_W    = FRAC_BITS + 1;
  localparam int WS_W   = 22;
  localparam int SUM_W  = WS_W + 1;
  localparam int PROD_W = STEP_W + SUM_W;

  // log2(2.7182) in Q1.16
  localparam logic [LOG_W-1:0] LOG2_BASE_Q16 = 17'd94546;
  // exponents at or above this give zero
  localparam int K_ZERO = 40;
  localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

  // Command and status between controller and datapath
  typedef struct packed {
    logic ld_in;
    logic do_sq;
    logic do_mul;
    logic do_exp;
    logic do_acc;
    logic ld_out;
  } gti_cmd_t;

  typedef struct packed {
    logic last;
  } gti_sts_t;

  // 2^(-j/16) in Q16, j = 0..16
  function automatic logic [V_W-1:0] pow2_neg(input logic [4:0] j);
    logic [V_W-1:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/gti_ctrl.sv
module gti_ctrl
  import gti_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  gti_sts_t sts,
  output gti_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_EXP  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  // Sequence one sample through the datapath
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.do_sq = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = ST_EXP;
      end
      ST_EXP: begin
        cmd.do_exp = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.do_acc = 1'b1;
        state_nxt  = sts.last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on load, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.ld_out)                out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/gti_datapath.sv
module gti_datapath
  import gti_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  gti_cmd_t          cmd,
  output gti_sts_t          sts,
  input  logic [X_W-1:0]    sample_x,
  input  logic [STEP_W-1:0] step_milli,
  input  logic              last_sample,
  output logic [RES_W-1:0]  integral_milli,
  output logic [USED_W-1:0] points_used,
  output logic              overflow_flag
);

  // Sample capture and exponent pipeline registers
  logic [MAG_W-1:0]  mag_r;
  logic [STEP_W-1:0] step_r;
  logic              last_r;
  logic [SQ_W-1:0]   sq_r;
  logic [T_W-1:0]    t_r;
  logic [K_W-1:0]    k_r;
  logic [V_W-1:0]    v_r;

  // Interval state
  logic [WS_W-1:0]   ws_r, ws_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [F_W-1:0]    first_r;
  logic              drop_r, drop_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  used_r;

  // Output register
  logic [RES_W-1:0]  res_r;
  logic [USED_W-1:0] pts_r;
  logic              ovf_r;

  logic [MAG_W-1:0]        mag;
  logic [15:0]             frac;
  logic [3:0]              idx;
  logic [11:0]             sub;
  logic [V_W-1:0]          tab_a, tab_b;
  logic [23:0]             slope;
  logic [V_W-1:0]          v;
  logic [V_W+FRAC_BITS-1:0] f_wide;
  logic [6:0]              shamt;
  logic [F_W-1:0]          f;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       prod_sh;
  logic [RES_W-1:0]        res;

  assign sts.last = last_r;

  // Absolute value of the Q8.8 sample
  assign mag = sample_x[X_W-1] ? MAG_W'(~sample_x + 16'd1) : sample_x;

  // Table interpolation of 2^(-r)
  assign frac  = t_r[31:16];
  assign idx   = frac[15:12];
  assign sub   = frac[11:0];
  assign tab_a = pow2_neg({1'b0, idx});
  assign tab_b = pow2_neg(5'({1'b0, idx} + 5'd1));
  assign slope = 24'(12'(tab_a - tab_b)) * 24'(sub);
  assign v     = tab_a - V_W'(slope >> 12);

  // Scale by 2^(-k)
  assign shamt  = 7'd16 + 7'(k_r[5:0]);
  assign f_wide = {v_r, {FRAC_BITS{1'b0}}} >> shamt;
  assign f      = (k_r >= K_W'(K_ZERO)) ? '0 : F_W'(f_wide);

  // Final scale and saturate
  assign prod    = PROD_W'(step_r) * PROD_W'(sum_r);
  assign prod_sh = prod >> (FRAC_BITS + 1);
  assign res     = (prod_sh > PROD_W'(RES_MAX)) ? RES_MAX : RES_W'(prod_sh);

  // Accumulate a non-last point, or drop it past the limit
  always_comb begin
    ws_nxt   = ws_r;
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    if (cmd.do_acc && !last_r) begin
      if (cnt_r == '0) begin
        cnt_nxt = CNT_W'(1);
      end else if (cnt_r < CNT_W'(MAX_POINTS - 1)) begin
        ws_nxt  = ws_r + WS_W'({f, 1'b0});
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end
    if (cmd.ld_out) begin
      ws_nxt   = '0;
      cnt_nxt  = '0;
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= '0;
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      ws_r   <= ws_nxt;
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      mag_r  <= mag;
      step_r <= step_milli;
      last_r <= last_sample;
    end
    if (cmd.do_sq)  sq_r <= SQ_W'(mag_r) * SQ_W'(mag_r);
    if (cmd.do_mul) t_r  <= T_W'(sq_r) * T_W'(LOG2_BASE_Q16);
    if (cmd.do_exp) begin
      v_r <= v;
      k_r <= t_r[T_W-1:32];
    end
    if (cmd.do_acc) begin
      if (!last_r && cnt_r == '0) first_r <= f;
      if (last_r) begin
        if (cnt_r == '0) begin
          sum_r  <= SUM_W'({f, 1'b0});
          used_r <= CNT_W'(1);
        end else begin
          sum_r  <= SUM_W'(ws_r) + SUM_W'(first_r) + SUM_W'(f);
          used_r <= cnt_r + CNT_W'(1);
        end
      end
    end
    if (cmd.ld_out) begin
      res_r <= res;
      pts_r <= USED_W'(used_r);
      ovf_r <= drop_r;
    end
  end

  assign integral_milli = res_r;
  assign points_used    = pts_r;
  assign overflow_flag  = ovf_r;

endmodule

// File: hdl/gaussian_trapezoid_integrator_core.sv
// Trapezoid-rule integrator of f(x) = 2.7182^(-x*x). Each input transfer
// carries one Q8.8 sample; tlast marks the final sample of an interval, and
// only on that transfer is the step width (thousandths) read. First and last
// points weigh 1, interior points 2; a lone point counts twice. Once
// MAX_POINTS - 1 points are held, further non-last samples are dropped and
// flagged. On the last sample one result is sent: the integral in thousandths
// (truncated, saturating), the number of points used and the drop flag.
// Items are taken one at a time: a non-last sample passes through capture,
// square, log2 scaling multiply, table interpolation, and shift and
// accumulate; a last sample adds the final step multiply. A last sample
// waits in its final step while the previous result still sits untaken in
// the output register.
module gaussian_trapezoid_integrator_core
  import gti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_x[15:0], step_milli[31:16]
  input  logic        in_tlast,   // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // integral_milli[18:0], points_used[22:19],
                                  // overflow_flag[23]
);

  gti_cmd_t cmd;
  gti_sts_t sts;

  logic [RES_W-1:0]  integral_milli;
  logic [USED_W-1:0] points_used;
  logic              overflow_flag;

  gti_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gti_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .sample_x       (in_tdata[15:0]),
    .step_milli     (in_tdata[31:16]),
    .last_sample    (in_tlast),
    .integral_milli (integral_milli),
    .points_used    (points_used),
    .overflow_flag  (overflow_flag)
  );

  assign out_tdata = {overflow_flag, points_used, integral_milli};

endmodule
